// File: hw/rtl/bufp_pkg.sv
// Shared constants, codes and types for the blob unscramble field parser.
`default_nettype none

package bufp_pkg;

    // Delay-line distance of the unscramble XOR
    localparam int SCRAMBLE_DISTANCE = 16;
    localparam int HIST_AW = (SCRAMBLE_DISTANCE > 1) ? $clog2(SCRAMBLE_DISTANCE) : 1;
    localparam int POS_W   = $clog2(SCRAMBLE_DISTANCE + 1);

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int VALUE_W = 15;

    // Parse phases
    localparam logic [3:0] PH_MARK1   = 4'd0;
    localparam logic [3:0] PH_LEN1_LO = 4'd1;
    localparam logic [3:0] PH_LEN1_HI = 4'd2;
    localparam logic [3:0] PH_SKIP1   = 4'd3;
    localparam logic [3:0] PH_MARK2   = 4'd4;
    localparam logic [3:0] PH_TYPE_LO = 4'd5;
    localparam logic [3:0] PH_TYPE_HI = 4'd6;
    localparam logic [3:0] PH_MARK3   = 4'd7;
    localparam logic [3:0] PH_LEN2_LO = 4'd8;
    localparam logic [3:0] PH_LEN2_HI = 4'd9;
    localparam logic [3:0] PH_DATA    = 4'd10;
    localparam logic [3:0] PH_DONE    = 4'd11;

    // Result kinds
    localparam logic [1:0] KIND_TYPE  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_INT      = 2'd1;
    localparam logic [1:0] ERR_INT_HI   = 2'd2;
    localparam logic [1:0] ERR_BYTES    = 2'd3;

    localparam logic [7:0] VARINT_MORE = 8'h80;

    typedef struct packed {
        logic [7:0] data;
        logic       final_flag;
    } item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [VALUE_W-1:0] value;
        logic [1:0]         err;
        logic               done;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

`default_nettype wire

// File: hw/rtl/bufp_if.sv
// Valid/ready channel interfaces for blob bytes in and parsed results out.
`default_nettype none

interface bufp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       final_byte;

    modport source (output valid, output byte_in, output final_byte, input ready);
    modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface

interface bufp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [14:0] value;
    logic [1:0]  error_code;
    logic        record_done;

    modport source (output valid, output result_kind, output value, output error_code,
                    output record_done, input ready);
    modport sink   (input valid, input result_kind, input value, input error_code,
                    input record_done, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bufp_unscramble.sv
// History RAM delay line and byte unscramble stage.
`default_nettype none

module bufp_unscramble
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic [7:0]     in_data,
    input  wire logic           in_final,
    output logic                in_ready,
    output logic                item_valid,
    output bufp_pkg::item_t     item,
    input  wire logic           item_take
);

    logic [7:0] hist_mem [bufp_pkg::SCRAMBLE_DISTANCE];
    logic [7:0] hist_rd_reg;
    logic [7:0] raw_reg;
    logic       fin_reg;
    logic       xen_reg;
    logic       valid_reg;
    logic [bufp_pkg::HIST_AW-1:0] wp_reg;
    logic [bufp_pkg::HIST_AW-1:0] wp_next;
    logic [bufp_pkg::POS_W-1:0]   pos_reg;
    logic [bufp_pkg::POS_W-1:0]   pos_next;
    logic accept;
    logic pos_full;

    assign in_ready = !valid_reg || item_take;
    assign accept   = in_valid && in_ready;
    assign pos_full = (pos_reg == bufp_pkg::POS_W'(bufp_pkg::SCRAMBLE_DISTANCE));

    assign wp_next = (wp_reg == bufp_pkg::HIST_AW'(bufp_pkg::SCRAMBLE_DISTANCE - 1))
                     ? '0 : wp_reg + 1'b1;

    always_comb
    begin
        if (in_final)
            pos_next = '0;
        else if (pos_full)
            pos_next = pos_reg;
        else
            pos_next = pos_reg + 1'b1;
    end

    // Read-before-write: the slot holds the byte from one full lap ago
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_rd_reg      <= hist_mem[wp_reg];
            hist_mem[wp_reg] <= in_data;
            raw_reg          <= in_data;
            fin_reg          <= in_final;
            xen_reg          <= pos_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            wp_reg    <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                valid_reg <= 1'b1;
                wp_reg    <= wp_next;
                pos_reg   <= pos_next;
            end
            else if (item_take)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign item_valid      = valid_reg;
    assign item.data       = raw_reg ^ (xen_reg ? hist_rd_reg : 8'h00);
    assign item.final_flag = fin_reg;

endmodule

`default_nettype wire

// File: hw/rtl/bufp_parser.sv
// Field parse state machine: markers, varints, skip field and auth data.
`default_nettype none

module bufp_parser
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    input  wire bufp_pkg::item_t               item,
    output logic                               item_take,
    input  wire logic [bufp_pkg::FIFO_CW-1:0]  free,
    output bufp_pkg::push_t                    push
);

    logic [3:0]  phase_reg;
    logic [3:0]  phase_next;
    logic [3:0]  phase_step;
    logic [6:0]  vlow_reg;
    logic [6:0]  vlow_next;
    logic [14:0] left_reg;
    logic [14:0] left_next;
    logic [14:0] left_dec;
    logic [14:0] len;
    logic [7:0]  b;
    logic        r0_valid;
    bufp_pkg::result_t r0;
    bufp_pkg::result_t rerr;
    logic [1:0]  err;
    logic        fin;
    logic [1:0]  need;

    assign b        = item.data;
    assign fin      = item.final_flag;
    assign left_dec = left_reg - 15'd1;

    always_comb
    begin
        phase_step = phase_reg;
        vlow_next  = vlow_reg;
        left_next  = left_reg;
        r0_valid   = 1'b0;
        r0         = '0;
        len        = '0;
        case (phase_reg)
            bufp_pkg::PH_MARK1: phase_step = bufp_pkg::PH_LEN1_LO;
            bufp_pkg::PH_MARK2: phase_step = bufp_pkg::PH_TYPE_LO;
            bufp_pkg::PH_MARK3: phase_step = bufp_pkg::PH_LEN2_LO;
            bufp_pkg::PH_LEN1_LO, bufp_pkg::PH_LEN1_HI:
            begin
                if (phase_reg == bufp_pkg::PH_LEN1_LO && (b & bufp_pkg::VARINT_MORE) != 8'h00)
                begin
                    vlow_next  = b[6:0];
                    phase_step = bufp_pkg::PH_LEN1_HI;
                end
                else
                begin
                    len = (phase_reg == bufp_pkg::PH_LEN1_LO) ? {7'd0, b} : {b, vlow_reg};
                    left_next  = len;
                    phase_step = (len != '0) ? bufp_pkg::PH_SKIP1 : bufp_pkg::PH_MARK2;
                end
            end
            bufp_pkg::PH_SKIP1:
            begin
                left_next = left_dec;
                if (left_dec == '0)
                    phase_step = bufp_pkg::PH_MARK2;
            end
            bufp_pkg::PH_TYPE_LO:
            begin
                if ((b & bufp_pkg::VARINT_MORE) != 8'h00)
                begin
                    vlow_next  = b[6:0];
                    phase_step = bufp_pkg::PH_TYPE_HI;
                end
                else
                begin
                    r0_valid   = 1'b1;
                    r0.kind    = bufp_pkg::KIND_TYPE;
                    r0.value   = {7'd0, b};
                    phase_step = bufp_pkg::PH_MARK3;
                end
            end
            bufp_pkg::PH_TYPE_HI:
            begin
                r0_valid   = 1'b1;
                r0.kind    = bufp_pkg::KIND_TYPE;
                r0.value   = {b, vlow_reg};
                phase_step = bufp_pkg::PH_MARK3;
            end
            bufp_pkg::PH_LEN2_LO, bufp_pkg::PH_LEN2_HI:
            begin
                if (phase_reg == bufp_pkg::PH_LEN2_LO && (b & bufp_pkg::VARINT_MORE) != 8'h00)
                begin
                    vlow_next  = b[6:0];
                    phase_step = bufp_pkg::PH_LEN2_HI;
                end
                else
                begin
                    len = (phase_reg == bufp_pkg::PH_LEN2_LO) ? {7'd0, b} : {b, vlow_reg};
                    left_next = len;
                    if (len == '0)
                    begin
                        r0_valid   = 1'b1;
                        r0.kind    = bufp_pkg::KIND_EMPTY;
                        r0.done    = 1'b1;
                        phase_step = bufp_pkg::PH_DONE;
                    end
                    else
                    begin
                        phase_step = bufp_pkg::PH_DATA;
                    end
                end
            end
            bufp_pkg::PH_DATA:
            begin
                left_next = left_dec;
                r0_valid  = 1'b1;
                r0.kind   = bufp_pkg::KIND_DATA;
                r0.value  = {7'd0, b};
                r0.done   = (left_dec == '0);
                if (left_dec == '0)
                    phase_step = bufp_pkg::PH_DONE;
            end
            default: phase_step = bufp_pkg::PH_DONE;
        endcase
    end

    // Truncation is judged on the phase reached after this byte
    always_comb
    begin
        err = bufp_pkg::ERR_NONE;
        if (fin)
        begin
            case (phase_step)
                bufp_pkg::PH_MARK1, bufp_pkg::PH_LEN1_LO, bufp_pkg::PH_MARK2,
                bufp_pkg::PH_TYPE_LO, bufp_pkg::PH_MARK3, bufp_pkg::PH_LEN2_LO:
                    err = bufp_pkg::ERR_INT;
                bufp_pkg::PH_LEN1_HI, bufp_pkg::PH_TYPE_HI, bufp_pkg::PH_LEN2_HI:
                    err = bufp_pkg::ERR_INT_HI;
                bufp_pkg::PH_SKIP1, bufp_pkg::PH_DATA:
                    err = bufp_pkg::ERR_BYTES;
                default:
                    err = bufp_pkg::ERR_NONE;
            endcase
        end
    end

    always_comb
    begin
        rerr      = '0;
        rerr.kind = bufp_pkg::KIND_ERROR;
        rerr.err  = err;
        rerr.done = 1'b1;
        push      = '0;
        if (r0_valid)
        begin
            push.res0  = r0;
            push.res1  = rerr;
            push.count = (err != bufp_pkg::ERR_NONE) ? 2'd2 : 2'd1;
        end
        else
        begin
            push.res0  = rerr;
            push.count = (err != bufp_pkg::ERR_NONE) ? 2'd1 : 2'd0;
        end
        if (!item_take)
            push.count = 2'd0;
    end

    // Results this byte will push, checked against queue space before taking it
    assign need       = {1'b0, r0_valid} + {1'b0, (err != bufp_pkg::ERR_NONE)};
    assign item_take  = item_valid && (bufp_pkg::FIFO_CW'(need) <= free);
    assign phase_next = fin ? bufp_pkg::PH_MARK1 : phase_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bufp_pkg::PH_MARK1;
            vlow_reg  <= '0;
            left_reg  <= '0;
        end
        else if (item_take)
        begin
            phase_reg <= phase_next;
            vlow_reg  <= fin ? 7'd0 : vlow_next;
            left_reg  <= fin ? 15'd0 : left_next;
        end
    end

`ifndef SYNTHESIS
    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> ({1'b0, push.count} <= free))
        else $error("parser pushed more results than the queue can hold");

    a_fin_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && item.final_flag |=> phase_reg == bufp_pkg::PH_MARK1
            && left_reg == '0)
        else $error("parser did not rewind after the last byte of a blob");

    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && phase_reg == bufp_pkg::PH_DONE |-> push.count == 2'd0)
        else $error("trailing byte produced a result");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/bufp_result_fifo.sv
// Small result queue taking up to two results per cycle and giving one when out_ready is high.
`default_nettype none

module bufp_result_fifo
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bufp_pkg::push_t               push,
    output logic [bufp_pkg::FIFO_CW-1:0]       free,
    output logic                               out_valid,
    output bufp_pkg::result_t                  out_res,
    input  wire logic                          out_ready
);

    bufp_pkg::result_t entry_reg [bufp_pkg::FIFO_DEPTH];
    logic [bufp_pkg::FIFO_AW-1:0] wp_reg;
    logic [bufp_pkg::FIFO_AW-1:0] rp_reg;
    logic [bufp_pkg::FIFO_AW-1:0] wp_plus1;
    logic [bufp_pkg::FIFO_CW-1:0] count_reg;
    logic [bufp_pkg::FIFO_CW-1:0] count_next;
    logic pop;

    assign free      = bufp_pkg::FIFO_CW'(bufp_pkg::FIFO_DEPTH) - count_reg;
    assign out_valid = (count_reg != '0);
    assign out_res   = entry_reg[rp_reg];
    assign pop       = out_valid && out_ready;
    assign wp_plus1  = wp_reg + 1'b1;
    assign count_next = count_reg + bufp_pkg::FIFO_CW'(push.count)
                        - bufp_pkg::FIFO_CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wp_reg] <= push.res0;
        if (push.count == 2'd2)
            entry_reg[wp_plus1] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_reg + bufp_pkg::FIFO_AW'(push.count);
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bufp_pkg::FIFO_CW'(bufp_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_empty_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> rp_reg == wp_reg)
        else $error("result queue pointers disagree when empty");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.count == 2'd0 |=> count_reg == $past(count_reg) - 1'b1)
        else $error("result queue count lost a transaction");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/blob_unscramble_field_parser_top.sv
// Top level: unscramble delay line, field parser and result queue.
// A byte is registered in the unscramble stage, and its results in the result queue.
// Throughput: one byte per cycle while the queue has room; results leave one by one.
// The history RAM is read and written once per byte, at the slot one lap back.
// Reset (rst_n low, asynchronous) empties all stages and rewinds the parser;
// no memory clearing pass is needed, the XOR stays off for each blob's first 16 bytes.
`default_nettype none

module blob_unscramble_field_parser_top
(
    input  wire logic clk,
    input  wire logic rst_n,
    bufp_in_if.sink   in_ch,
    bufp_out_if.source out_ch
);

    logic              item_valid;
    logic              item_take;
    bufp_pkg::item_t   item;
    bufp_pkg::push_t   push;
    bufp_pkg::result_t out_res;
    logic [bufp_pkg::FIFO_CW-1:0] free;

    bufp_unscramble u_unscramble
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_data    (in_ch.byte_in),
        .in_final   (in_ch.final_byte),
        .in_ready   (in_ch.ready),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    bufp_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .free       (free),
        .push       (push)
    );

    bufp_result_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .free       (free),
        .out_valid  (out_ch.valid),
        .out_res    (out_res),
        .out_ready  (out_ch.ready)
    );

    assign out_ch.result_kind = out_res.kind;
    assign out_ch.value       = out_res.value;
    assign out_ch.error_code  = out_res.err;
    assign out_ch.record_done = out_res.done;

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the blob unscramble field parser: directed and random blobs.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bufp_pkg::*;

    localparam int RANDOM_BYTES = 1150;
    localparam int MAX_PRINTS   = 30;

    logic clk;
    logic rst_n;

    bufp_in_if  in_ch ();
    bufp_out_if out_ch ();

    blob_unscramble_field_parser_top uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Own copy of the unscramble and parse state
    logic [7:0]  raw_history [SCRAMBLE_DISTANCE];
    int unsigned history_fill;
    logic [3:0]  field_phase;
    logic [6:0]  varint_lo7;
    logic [14:0] field_left;

    result_t     auth_results_q [$];
    logic [7:0]  blob_plain [$];

    int unsigned mismatches;
    int unsigned bytes_sent;
    int unsigned blobs_sent;
    int unsigned results_checked;
    int unsigned errors_checked;
    int          burst_left;
    logic [9:0]  stall_cycle = '0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
        begin
            $display("%0t ns  mismatch: %s", $time, what);
        end
    endtask

    task automatic rewind_parser();
        int i;
        for (i = 0; i < SCRAMBLE_DISTANCE; i++)
        begin
            raw_history[i] = 8'h00;
        end
        history_fill = 0;
        field_phase  = PH_MARK1;
        varint_lo7   = '0;
        field_left   = '0;
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [14:0] value,
                               input logic [1:0] err, input logic done);
        result_t r;
        r.kind  = kind;
        r.value = value;
        r.err   = err;
        r.done  = done;
        auth_results_q.push_back(r);
    endtask

    // Unscramble one accepted byte, advance the parse and queue what it yields
    task automatic track_byte(input logic [7:0] raw, input logic fin);
        logic [7:0] b;
        logic [1:0] err;
        int i;
        b = raw;
        if (history_fill >= SCRAMBLE_DISTANCE)
        begin
            b = b ^ raw_history[SCRAMBLE_DISTANCE-1];
        end
        else
        begin
            history_fill++;
        end
        for (i = SCRAMBLE_DISTANCE - 1; i > 0; i--)
        begin
            raw_history[i] = raw_history[i-1];
        end
        raw_history[0] = raw;

        case (field_phase)
            PH_MARK1: field_phase = PH_LEN1_LO;
            PH_MARK2: field_phase = PH_TYPE_LO;
            PH_MARK3: field_phase = PH_LEN2_LO;
            PH_LEN1_LO, PH_LEN1_HI:
            begin
                if (field_phase == PH_LEN1_LO && b[7])
                begin
                    varint_lo7  = b[6:0];
                    field_phase = PH_LEN1_HI;
                end
                else
                begin
                    field_left  = (field_phase == PH_LEN1_LO) ? {7'd0, b} : {b, varint_lo7};
                    field_phase = (field_left != 0) ? PH_SKIP1 : PH_MARK2;
                end
            end
            PH_SKIP1:
            begin
                field_left--;
                if (field_left == 0)
                begin
                    field_phase = PH_MARK2;
                end
            end
            PH_TYPE_LO:
            begin
                if (b[7])
                begin
                    varint_lo7  = b[6:0];
                    field_phase = PH_TYPE_HI;
                end
                else
                begin
                    push_result(KIND_TYPE, {7'd0, b}, ERR_NONE, 1'b0);
                    field_phase = PH_MARK3;
                end
            end
            PH_TYPE_HI:
            begin
                push_result(KIND_TYPE, {b, varint_lo7}, ERR_NONE, 1'b0);
                field_phase = PH_MARK3;
            end
            PH_LEN2_LO, PH_LEN2_HI:
            begin
                if (field_phase == PH_LEN2_LO && b[7])
                begin
                    varint_lo7  = b[6:0];
                    field_phase = PH_LEN2_HI;
                end
                else
                begin
                    field_left = (field_phase == PH_LEN2_LO) ? {7'd0, b} : {b, varint_lo7};
                    if (field_left == 0)
                    begin
                        push_result(KIND_EMPTY, '0, ERR_NONE, 1'b1);
                        field_phase = PH_DONE;
                    end
                    else
                    begin
                        field_phase = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                field_left--;
                push_result(KIND_DATA, {7'd0, b}, ERR_NONE, field_left == 0);
                if (field_left == 0)
                begin
                    field_phase = PH_DONE;
                end
            end
            default: field_phase = PH_DONE;
        endcase

        if (fin)
        begin
            case (field_phase)
                PH_MARK1, PH_LEN1_LO, PH_MARK2, PH_TYPE_LO, PH_MARK3, PH_LEN2_LO:
                    err = ERR_INT;
                PH_LEN1_HI, PH_TYPE_HI, PH_LEN2_HI:
                    err = ERR_INT_HI;
                PH_SKIP1, PH_DATA:
                    err = ERR_BYTES;
                default:
                    err = ERR_NONE;
            endcase
            if (err != ERR_NONE)
            begin
                push_result(KIND_ERROR, '0, err, 1'b1);
            end
            rewind_parser();
        end
    endtask

    // Sender: bursts of random length with random gaps; called at a rising edge
    task automatic send_byte(input logic [7:0] data, input logic fin);
        logic rdy;
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        in_ch.valid      <= 1'b1;
        in_ch.byte_in    <= data;
        in_ch.final_byte <= fin;
        do
        begin
            @(negedge clk);
            rdy = in_ch.ready;
            @(posedge clk);
        end
        while (rdy !== 1'b1);
        track_byte(data, fin);
        bytes_sent++;
        burst_left--;
    endtask

    // Scramble blob_plain so that it unscrambles back to itself, send the first cut bytes
    task automatic send_blob(input int cut);
        logic [7:0] raw [$];
        int i;
        raw = {};
        for (i = 0; i < blob_plain.size(); i++)
        begin
            if (i >= SCRAMBLE_DISTANCE)
            begin
                raw.push_back(blob_plain[i] ^ raw[i-SCRAMBLE_DISTANCE]);
            end
            else
            begin
                raw.push_back(blob_plain[i]);
            end
        end
        for (i = 0; i < cut; i++)
        begin
            send_byte(raw[i], i == cut - 1);
        end
        blobs_sent++;
    endtask

    task automatic push_varint(input int unsigned v, input bit two_bytes);
        logic [14:0] w;
        w = v[14:0];
        if (w < 128 && !two_bytes)
        begin
            blob_plain.push_back(w[7:0]);
        end
        else
        begin
            blob_plain.push_back({1'b1, w[6:0]});
            blob_plain.push_back(w[14:7]);
        end
    endtask

    // Hold the sender off until every queued result has been seen
    task automatic settle_results();
        in_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (auth_results_q.size() != 0);
    endtask

    task automatic test_zero_lengths();
        blob_plain = {8'h00, 8'h00, 8'hFF, 8'h05, 8'h00, 8'h00};
        send_blob(blob_plain.size());
    endtask

    // Two-byte auth type at its maximum, byte extremes, trailing byte on the final flag
    task automatic test_wide_fields();
        blob_plain = {8'hFF, 8'h01, 8'h00, 8'h80, 8'hFF, 8'hFF,
                      8'h00, 8'h02, 8'h00, 8'hFF, 8'hAA};
        send_blob(blob_plain.size());
    endtask

    task automatic test_early_end();
        blob_plain = {8'h00};
        send_blob(1);
        blob_plain = {8'h00, 8'h80};
        send_blob(2);
        blob_plain = {8'h00, 8'h03, 8'h11};
        send_blob(3);
    endtask

    task automatic test_random_blobs();
        int unsigned start;
        int n;
        int cut;
        int l1;
        int l2;
        int pick;
        int blob_no;
        start   = bytes_sent;
        blob_no = 0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            blob_plain = {};
            if ($urandom_range(0, 9) == 0)
            begin
                // noise blob
                repeat ($urandom_range(1, 24)) blob_plain.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                blob_plain.push_back(8'($urandom_range(0, 255)));
                l1 = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 160)
                                                  : $urandom_range(0, 12);
                push_varint(l1, $urandom_range(0, 7) == 0);
                repeat (l1) blob_plain.push_back(8'($urandom_range(0, 255)));
                blob_plain.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 0)
                begin
                    blob_plain.push_back(8'($urandom_range(0, 127)));
                end
                else
                begin
                    push_varint($urandom_range(0, 32767), 1'b1);
                end
                blob_plain.push_back(8'($urandom_range(0, 255)));
                pick = $urandom_range(0, 9);
                l2 = (pick < 2) ? 0 : (pick == 2) ? $urandom_range(100, 180)
                                                  : $urandom_range(1, 16);
                push_varint(l2, $urandom_range(0, 7) == 0);
                repeat (l2) blob_plain.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 2) == 0)
                begin
                    repeat ($urandom_range(1, 4)) blob_plain.push_back(8'($urandom_range(0, 255)));
                end
            end
            n   = blob_plain.size();
            cut = n;
            if (n > 1 && $urandom_range(0, 2) == 0)
            begin
                cut = $urandom_range(1, n - 1);
            end
            send_blob(cut);
            blob_no++;
            if (blob_no % 15 == 0)
            begin
                settle_results();
            end
        end
    endtask

    // Receiver stall pattern: the mode follows bits 9:8 of the free-running stall_cycle counter
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            stall_cycle <= stall_cycle + 1'b1;
            case (stall_cycle[9:8])
                2'd0:    out_ch.ready <= 1'b1;
                2'd1:    out_ch.ready <= 1'($urandom_range(0, 1));
                2'd2:    out_ch.ready <= (stall_cycle[2:0] > 3'd2);
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic check_result();
        result_t want;
        if (auth_results_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result kind %0d value %0d err %0d done %0d",
                            out_ch.result_kind, out_ch.value, out_ch.error_code,
                            out_ch.record_done));
        end
        else
        begin
            want = auth_results_q.pop_front();
            results_checked++;
            if (want.kind == KIND_ERROR)
            begin
                errors_checked++;
            end
            if (out_ch.result_kind !== want.kind)
                report_mismatch($sformatf("result_kind %0d, want %0d",
                                out_ch.result_kind, want.kind));
            if (out_ch.value !== want.value)
                report_mismatch($sformatf("value %0d, want %0d", out_ch.value, want.value));
            if (out_ch.error_code !== want.err)
                report_mismatch($sformatf("error_code %0d, want %0d",
                                out_ch.error_code, want.err));
            if (out_ch.record_done !== want.done)
                report_mismatch($sformatf("record_done %0d, want %0d",
                                out_ch.record_done, want.done));
        end
    endtask

    // Outputs are stable around the falling edge; a transaction follows at the next rise
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            check_result();
        end
    end

    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.byte_in    = 8'h00;
        in_ch.final_byte = 1'b0;
        mismatches       = 0;
        bytes_sent       = 0;
        blobs_sent       = 0;
        results_checked  = 0;
        errors_checked   = 0;
        burst_left       = 0;
        rewind_parser();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_zero_lengths();
        test_wide_fields();
        test_early_end();
        settle_results();
        test_random_blobs();

        settle_results();
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes in %0d blobs (directed and random, incl. truncated and noise)",
                 bytes_sent, blobs_sent);
        $display("Checked %0d results, %0d of them truncation errors; %0d mismatches",
                 results_checked, errors_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
